// ----- hdl/b64c_pkg.sv -----
// Package for the Base64 stream codec: mode codes, the result group type and
// the alphabet mapping functions. No dependencies.
package b64c_pkg;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Up to four results caused by one input item; bytes[0] goes out first.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            done;
        logic            bad;
    } group_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end
        else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end
        else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end
        else if (v == 6'd62) begin
            c = 8'h2B;
        end
        else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    function automatic sextet_t dec_sextet(input logic [7:0] ch);
        sextet_t s;
        s.valid = 1'b1;
        if (ch inside {[8'h41:8'h5A]}) begin
            s.value = 6'(ch - 8'h41);
        end
        else if (ch inside {[8'h61:8'h7A]}) begin
            s.value = 6'(ch - 8'h61 + 8'd26);
        end
        else if (ch inside {[8'h30:8'h39]}) begin
            s.value = 6'(ch - 8'h30 + 8'd52);
        end
        else if (ch == 8'h2B) begin
            s.value = 6'd62;
        end
        else if (ch == 8'h2F) begin
            s.value = 6'd63;
        end
        else begin
            s.valid = 1'b0;
            s.value = 6'd0;
        end
        return s;
    endfunction

    // A single error result.
    function automatic group_t error_group();
        group_t g;
        g       = '0;
        g.count = 3'd1;
        g.bad   = 1'b1;
        return g;
    endfunction

    // Flushes a partial decode group of two or three sextets; one sextet or
    // none is an error.
    function automatic group_t flush_partial(input logic [23:0] bits,
                                             input logic [1:0]  cnt);
        group_t g;
        g = '0;
        case (cnt)
            2'd2:
            begin
                g.bytes[0] = bits[11:4];
                g.count    = 3'd1;
            end
            2'd3:
            begin
                g.bytes[0] = bits[17:10];
                g.bytes[1] = bits[9:2];
                g.count    = 3'd2;
            end
            default:
            begin
                g = error_group();
            end
        endcase
        return g;
    endfunction

endpackage

// ----- hdl/b64c_if.sv -----
// Channel interfaces of the Base64 stream codec: input items, results and
// the mode register write channel. No dependencies.
interface b64c_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface b64c_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;
    logic       bad_char;

    modport source (output valid, output out_byte, output run_last,
                    output stream_done, output bad_char, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input stream_done, input bad_char, output ready);
endinterface

interface b64c_cfg_if;
    logic valid;
    logic ready;
    logic codec_mode;

    modport source (output valid, output codec_mode, input ready);
    modport sink   (input valid, input codec_mode, output ready);
endinterface

// ----- hdl/base64_stream_codec.sv -----
// Top level of the Base64 stream codec (RFC 4648 alphabet).
// Depends on b64c_pkg, the channel interfaces, b64c_core and b64c_serial.
//
// Usage:
//   data_ch carries one byte (encode) or one character (decode) per
//   transaction, with end_of_stream on the final item of a stream.
//   result_ch carries the results: four characters per three bytes when
//   encoding (padded with '=' at the end), three bytes per four characters
//   when decoding. run_last marks the last result of an item, stream_done the
//   final result of a stream, bad_char a decode error result.
//   cfg writes codec_mode (0 encode, 1 decode) and clears the group state;
//   write it only while no transaction is in flight.
// An accepted item is held in the input register of b64c_core; its
//   results go to the group register in b64c_serial, which drives result_ch.
// The results of an item leave result_ch one per transaction; decoding
//   runs at one character per cycle while the receiver does not stall, and
//   items with no result pass at one per cycle. The result serializer, one
//   result per cycle while result_ch.ready is high, sets the rate.
// Reset clears the mode to encode, the group state and both registers.
// When the receiver stalls, the current result holds and items that cause no
// result still pass; the next item with results waits and data_ch.ready drops.
module base64_stream_codec
    import b64c_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    b64c_cfg_if.sink cfg,
    b64c_in_if.sink  data_ch,
    b64c_out_if.source result_ch
);

    logic   grp_valid;
    logic   grp_ok;
    group_t grp;

    assign cfg.ready = 1'b1;

    b64c_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.valid),
        .cfg_mode  (cfg.codec_mode),
        .in_valid  (data_ch.valid),
        .in_ready  (data_ch.ready),
        .in_data   (data_ch.data_byte),
        .in_eos    (data_ch.end_of_stream),
        .grp_ok    (grp_ok),
        .grp_valid (grp_valid),
        .grp       (grp)
    );

    b64c_serial u_serial (
        .clk             (clk),
        .rst_n           (rst_n),
        .grp_valid       (grp_valid),
        .grp             (grp),
        .grp_ok          (grp_ok),
        .out_valid       (result_ch.valid),
        .out_ready       (result_ch.ready),
        .out_byte        (result_ch.out_byte),
        .out_run_last    (result_ch.run_last),
        .out_stream_done (result_ch.stream_done),
        .out_bad_char    (result_ch.bad_char)
    );

endmodule

// ----- hdl/b64c_core.sv -----
// Input register, codec state and per-item encode/decode logic of the Base64
// stream codec. Depends on b64c_pkg.
module b64c_core
    import b64c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_mode,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_data,
    input  logic       in_eos,
    input  logic       grp_ok,
    output logic       grp_valid,
    output group_t     grp
);

    logic        mode_reg;
    logic [23:0] bits_reg, bits_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        skip_reg, skip_next;
    logic        item_valid_reg;
    logic [7:0]  item_data_reg;
    logic        item_eos_reg;
    logic        process;

    logic [23:0] gb_enc;
    logic [23:0] gb_pad;
    logic [23:0] gb_dec;
    sextet_t     sx;
    group_t      res;

    always_comb
    begin
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        skip_next = skip_reg;
        res       = '0;
        gb_enc    = {bits_reg[15:0], item_data_reg};
        gb_pad    = (cnt_reg == 2'd1) ? {bits_reg[7:0], item_data_reg, 8'h00}
                                      : {item_data_reg, 16'h0000};
        sx        = dec_sextet(item_data_reg);
        gb_dec    = {bits_reg[17:0], sx.value};

        if (mode_reg == MODE_ENCODE) begin
            if (cnt_reg == 2'd2) begin
                res.bytes[0] = enc_char(gb_enc[23:18]);
                res.bytes[1] = enc_char(gb_enc[17:12]);
                res.bytes[2] = enc_char(gb_enc[11:6]);
                res.bytes[3] = enc_char(gb_enc[5:0]);
                res.count    = 3'd4;
                bits_next    = '0;
                cnt_next     = 2'd0;
            end
            else begin
                bits_next = gb_enc;
                cnt_next  = cnt_reg + 2'd1;
                if (item_eos_reg) begin
                    res.bytes[0] = enc_char(gb_pad[23:18]);
                    res.bytes[1] = enc_char(gb_pad[17:12]);
                    res.bytes[2] = (cnt_reg == 2'd1) ? enc_char(gb_pad[11:6]) : PAD_CHAR;
                    res.bytes[3] = PAD_CHAR;
                    res.count    = 3'd4;
                end
            end
            res.done = item_eos_reg;
        end
        else if (!skip_reg) begin
            if (item_data_reg == PAD_CHAR || !sx.valid) begin
                if (item_data_reg == PAD_CHAR) begin
                    res = flush_partial(bits_reg, cnt_reg);
                end
                else begin
                    res = error_group();
                end
                bits_next = '0;
                cnt_next  = 2'd0;
                skip_next = !item_eos_reg;
                res.done  = 1'b1;
            end
            else begin
                if (cnt_reg == 2'd3) begin
                    res.bytes[0] = gb_dec[23:16];
                    res.bytes[1] = gb_dec[15:8];
                    res.bytes[2] = gb_dec[7:0];
                    res.count    = 3'd3;
                    bits_next    = '0;
                    cnt_next     = 2'd0;
                end
                else begin
                    bits_next = gb_dec;
                    cnt_next  = cnt_reg + 2'd1;
                    if (item_eos_reg) begin
                        res = flush_partial(gb_dec, cnt_reg + 2'd1);
                    end
                end
                res.done = item_eos_reg;
            end
        end

        if (item_eos_reg) begin
            bits_next = '0;
            cnt_next  = 2'd0;
            skip_next = 1'b0;
        end
    end

    // An item with no result never waits for the serializer.
    assign process   = item_valid_reg && (res.count == 3'd0 || grp_ok);
    assign in_ready  = !item_valid_reg || process;
    assign grp_valid = item_valid_reg && (res.count != 3'd0);
    assign grp       = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= MODE_ENCODE;
            bits_reg       <= '0;
            cnt_reg        <= 2'd0;
            skip_reg       <= 1'b0;
            item_valid_reg <= 1'b0;
        end
        else begin
            if (cfg_we) begin
                mode_reg <= cfg_mode;
                bits_reg <= '0;
                cnt_reg  <= 2'd0;
                skip_reg <= 1'b0;
            end
            else if (process) begin
                bits_reg <= bits_next;
                cnt_reg  <= cnt_next;
                skip_reg <= skip_next;
            end
            if (in_ready) begin
                item_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            item_data_reg <= in_data;
            item_eos_reg  <= in_eos;
        end
    end

    // The encoder never holds a full group between items.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_ENCODE) |-> (cnt_reg != 2'd3))
        else $error("encoder holds three bytes between items");

    assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> (mode_reg == MODE_DECODE))
        else $error("skip flag set while encoding");

    assert property (@(posedge clk) disable iff (!rst_n)
        (process && item_eos_reg && !cfg_we) |=> (cnt_reg == 2'd0 && !skip_reg))
        else $error("state not cleared after end of stream");

    assert property (@(posedge clk) disable iff (!rst_n)
        (grp_valid && res.bad) |-> (res.count == 3'd1 && res.done))
        else $error("error result not a single final result");

endmodule

// ----- hdl/b64c_serial.sv -----
// Result group register and serializer of the Base64 stream codec: sends the
// up to four results of one item one per transaction. Depends on b64c_pkg.
module b64c_serial
    import b64c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       grp_valid,
    input  group_t     grp,
    output logic       grp_ok,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_run_last,
    output logic       out_stream_done,
    output logic       out_bad_char
);

    logic       valid_reg;
    logic [1:0] idx_reg;
    group_t     grp_reg;
    logic       last;

    assign last            = ({1'b0, idx_reg} == grp_reg.count - 3'd1);
    assign grp_ok          = !valid_reg || (out_ready && last);
    assign out_valid       = valid_reg;
    assign out_byte        = grp_reg.bytes[idx_reg];
    assign out_run_last    = last;
    assign out_stream_done = last && grp_reg.done;
    assign out_bad_char    = grp_reg.bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (grp_valid && grp_ok) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end
        else if (valid_reg && out_ready) begin
            if (last) begin
                valid_reg <= 1'b0;
            end
            else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_valid && grp_ok) begin
            grp_reg <= grp;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ({1'b0, idx_reg} < grp_reg.count))
        else $error("result index beyond group size");

    // A new group may only replace one whose final result leaves now.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !(out_ready && last)) |-> !grp_ok)
        else $error("group overwritten before it was sent");

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(idx_reg)))
        else $error("serializer advanced while stalled");

endmodule

// ----- bench/tb_base64_stream_codec.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for base64_stream_codec: encode and decode streams,
// error and pad handling, stalls on both channels and mode changes between runs.
// Depends on b64c_pkg, the channel interfaces in b64c_if.sv and the codec RTL.
module tb_base64_stream_codec;
    import b64c_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 8;
    localparam int PHASE_ITEMS = 76;
    localparam logic [0:63][7:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_done;
        logic       bad_char;
    } result_t;

    logic clk = 1'b0;
    logic rst_n;

    b64c_cfg_if cfg_if ();
    b64c_in_if  data_if ();
    b64c_out_if result_if ();

    base64_stream_codec u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_if),
        .data_ch   (data_if),
        .result_ch (result_if)
    );

    always #1 clk = ~clk;

    // Codec state as predicted by the bench.
    logic        pred_mode;
    logic [23:0] pred_bits;
    int          pred_count;
    logic        pred_skip;

    result_t     step_res [0:3];
    int          step_n;
    result_t     expected_q [$];
    result_t     got_res;
    result_t     want_res;

    int          error_count = 0;
    int unsigned cycle_count = 0;
    int          hold_request = 0;
    bit          tx_gaps_on = 1'b1;
    bit          rx_stalls_on = 1'b1;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int rand_gap();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(12, 40);
        end
        return $urandom_range(0, 3);
    endfunction

    function automatic int sextet_value(input logic [7:0] ch);
        for (int i = 0; i < 64; i++) begin
            if (ALPHABET[i] == ch) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void add_result(input logic [7:0] b, input logic bad);
        step_res[step_n] = {b, 1'b0, 1'b0, bad};
        step_n++;
    endfunction

    // Emits the bytes of a partial decode group; too few sextets is an error.
    function automatic void flush_decode();
        if (pred_count == 2) begin
            add_result(pred_bits[11:4], 1'b0);
        end
        else if (pred_count == 3) begin
            add_result(pred_bits[17:10], 1'b0);
            add_result(pred_bits[9:2], 1'b0);
        end
        else begin
            add_result(8'h00, 1'b1);
        end
    endfunction

    function automatic void clear_groups();
        pred_bits  = '0;
        pred_count = 0;
        pred_skip  = 1'b0;
    endfunction

    // Works out the results of one accepted item and queues them.
    function automatic void predict_item(input logic [7:0] b, input logic eos);
        logic        done;
        logic [23:0] padded;
        int          v;
        step_n = 0;
        done   = 1'b0;
        if (pred_mode == MODE_ENCODE) begin
            pred_bits = {pred_bits[15:0], b};
            pred_count++;
            if (pred_count == 3) begin
                for (int k = 0; k < 4; k++) begin
                    add_result(ALPHABET[pred_bits[23 - 6 * k -: 6]], 1'b0);
                end
                pred_bits  = '0;
                pred_count = 0;
            end
            else if (eos) begin
                padded = (pred_count == 1) ? {pred_bits[7:0], 16'h0000}
                                           : {pred_bits[15:0], 8'h00};
                add_result(ALPHABET[padded[23:18]], 1'b0);
                add_result(ALPHABET[padded[17:12]], 1'b0);
                add_result((pred_count == 2) ? ALPHABET[padded[11:6]] : PAD_CHAR, 1'b0);
                add_result(PAD_CHAR, 1'b0);
            end
            done = eos;
        end
        else if (!pred_skip) begin
            v = sextet_value(b);
            if (b == PAD_CHAR || v < 0) begin
                if (b == PAD_CHAR) begin
                    flush_decode();
                end
                else begin
                    add_result(8'h00, 1'b1);
                end
                pred_bits  = '0;
                pred_count = 0;
                pred_skip  = !eos;
                done       = 1'b1;
            end
            else begin
                pred_bits = {pred_bits[17:0], v[5:0]};
                pred_count++;
                if (pred_count == 4) begin
                    add_result(pred_bits[23:16], 1'b0);
                    add_result(pred_bits[15:8], 1'b0);
                    add_result(pred_bits[7:0], 1'b0);
                    pred_bits  = '0;
                    pred_count = 0;
                end
                else if (eos) begin
                    flush_decode();
                end
                done = eos;
            end
        end
        if (step_n > 0) begin
            step_res[step_n - 1].run_last    = 1'b1;
            step_res[step_n - 1].stream_done = done;
        end
        for (int i = 0; i < step_n; i++) begin
            expected_q.push_back(step_res[i]);
        end
        if (eos) begin
            clear_groups();
        end
    endfunction

    task automatic send_item(input logic [7:0] b, input logic eos);
        int gap;
        gap = tx_gaps_on ? rand_gap() : 0;
        if (gap > 0) begin
            @(negedge clk);
            data_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        data_if.valid         <= 1'b1;
        data_if.data_byte     <= b;
        data_if.end_of_stream <= eos;
        do @(posedge clk); while (!data_if.ready);
        predict_item(b, eos);
    endtask

    task automatic send_chars(input string s, input bit eos_on_last);
        for (int i = 0; i < s.len(); i++) begin
            send_item(s[i], eos_on_last && (i == s.len() - 1));
        end
    endtask

    // Lets every outstanding result arrive, then waits out items that cause none.
    task automatic drain_results();
        @(negedge clk);
        data_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        @(negedge clk);
        cfg_if.valid      <= 1'b1;
        cfg_if.codec_mode <= mode;
        do @(posedge clk); while (!cfg_if.ready);
        pred_mode = mode;
        clear_groups();
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_encode_directed();
        // Full groups, a one-byte tail, a two-byte tail and a group closed by the end mark.
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h7F, 1'b1);
        send_item(8'hA5, 1'b0);
        send_item(8'h5A, 1'b1);
        send_item(8'h01, 1'b0);
        send_item(8'hFE, 1'b0);
        send_item(8'hC3, 1'b1);
        drain_results();
    endtask

    task automatic test_decode_directed();
        write_mode(MODE_DECODE);
        send_chars("/+az", 1'b0);
        // A pad after two sextets ends the stream; the rest is skipped.
        send_chars("TQ=", 1'b0);
        send_chars("x", 1'b1);
        send_chars("T*", 1'b0);
        send_chars("A", 1'b1);
        send_chars("T=", 1'b1);
        send_chars("TW", 1'b1);
        send_chars("Q", 1'b1);
        send_item(8'hFF, 1'b1);
        drain_results();
    endtask

    task automatic test_backpressure();
        write_mode(MODE_ENCODE);
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        hold_request = 80;
        for (int i = 0; i < 15; i++) begin
            send_item(8'($urandom_range(0, 255)), i == 14);
        end
        drain_results();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    task automatic send_encode_stream(inout int sent);
        int len;
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
            // Now and then a stream is left open and the next one continues it.
            send_item(8'($urandom_range(0, 255)),
                      (i == len - 1) && ($urandom_range(0, 9) != 0));
        end
        sent += len;
    endtask

    task automatic send_decode_stream(inout int sent);
        logic [7:0] chars [$];
        int         kind;
        int         nchar;
        int         tail;
        int         pos;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            nchar = $urandom_range(1, 6);
            for (int i = 0; i < nchar; i++) begin
                send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
            sent += nchar;
        end
        else begin
            nchar = 4 * $urandom_range(0, 3);
            tail  = $urandom_range(0, 3);
            nchar += tail;
            if (nchar == 0) begin
                nchar = 1;
            end
            for (int i = 0; i < nchar; i++) begin
                chars.push_back(ALPHABET[$urandom_range(0, 63)]);
            end
            if (tail >= 2 && $urandom_range(0, 2) != 0) begin
                chars.push_back(PAD_CHAR);
                if (tail == 2 && $urandom_range(0, 1) == 0) begin
                    chars.push_back(PAD_CHAR);
                end
            end
            if (kind < 25) begin
                pos = $urandom_range(0, chars.size() - 1);
                chars[pos] = 8'($urandom_range(0, 255));
            end
            for (int i = 0; i < chars.size(); i++) begin
                send_item(chars[i],
                          (i == chars.size() - 1) && ($urandom_range(0, 9) != 0));
            end
            sent += chars.size();
        end
    endtask

    task automatic test_random_streams();
        int sent;
        for (int phase = 0; phase < 6; phase++) begin
            write_mode(phase[0] ? MODE_DECODE : MODE_ENCODE);
            // Phases two and three run with no idling at all.
            tx_gaps_on   = (phase != 2) && (phase != 3);
            rx_stalls_on = (phase != 2) && (phase != 3);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (pred_mode == MODE_ENCODE) begin
                    send_encode_stream(sent);
                end
                else begin
                    send_decode_stream(sent);
                end
            end
            drain_results();
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin : result_ready_ctl
        int stall_left;
        stall_left = 0;
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            else if (stall_left == 0 && rx_stalls_on && $urandom_range(0, 2) == 0) begin
                stall_left = rand_gap();
            end
            if (stall_left > 0) begin
                result_if.ready <= 1'b0;
                stall_left--;
            end
            else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // Each result transaction is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready) begin
            got_res = {result_if.out_byte, result_if.run_last,
                       result_if.stream_done, result_if.bad_char};
            if (expected_q.size() == 0) begin
                report_error($sformatf("unexpected result %h", got_res));
            end
            else begin
                want_res = expected_q.pop_front();
                if (got_res.out_byte != want_res.out_byte) begin
                    report_error($sformatf("out_byte %h, expected %h",
                                           got_res.out_byte, want_res.out_byte));
                end
                if (got_res.run_last != want_res.run_last) begin
                    report_error($sformatf("run_last %b, expected %b",
                                           got_res.run_last, want_res.run_last));
                end
                if (got_res.stream_done != want_res.stream_done) begin
                    report_error($sformatf("stream_done %b, expected %b",
                                           got_res.stream_done, want_res.stream_done));
                end
                if (got_res.bad_char != want_res.bad_char) begin
                    report_error($sformatf("bad_char %b, expected %b",
                                           got_res.bad_char, want_res.bad_char));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.codec_mode     = MODE_ENCODE;
        data_if.valid         = 1'b0;
        data_if.data_byte     = 8'h00;
        data_if.end_of_stream = 1'b0;
        pred_mode             = MODE_ENCODE;
        clear_groups();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_encode_directed();
        test_decode_directed();
        test_backpressure();
        test_random_streams();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end
        else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- base64_stream_codec.f -----
hdl/b64c_pkg.sv
hdl/b64c_if.sv
hdl/b64c_core.sv
hdl/b64c_serial.sv
hdl/base64_stream_codec.sv
bench/tb_base64_stream_codec.sv
